// ===== design/rmsf_pkg.sv =====
`default_nettype none
package rmsf_pkg;

  localparam int AREA_W         = 23;
  localparam int PIX_W          = 11;
  localparam int HU_W           = 32;
  localparam int HU_FRAC        = 16;
  localparam int ORI_W          = 15;
  localparam int NORM_W         = 30;
  localparam int CORD_W         = 34;
  localparam int ANG_W          = 28;
  localparam int STEP_W         = 5;
  localparam int CORDIC_STEPS   = 24;
  localparam int COORD_BITS_DEF = 11;
  localparam int IN_DATA_W      = 24;
  localparam int OUT_DATA_W     = 128;

  localparam logic [AREA_W-1:0] AREA_MAX     = AREA_W'(4194304);
  localparam logic [AREA_W-1:0] MIN_SIZE_RST = AREA_W'(20000);

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(26353589);
  localparam logic signed [ANG_W-1:0] ROUND_HALF  = ANG_W'(2048);
  localparam logic signed [ANG_W-1:0] ORI_MAX     = ANG_W'(12868);

  // Operation sequence for the shared multiplier and divider.
  typedef enum logic [3:0] {
    OP_NN, OP_N3, OP_NXX, OP_SXX, OP_NYY, OP_SYY, OP_NXY, OP_SXY,
    OP_XX, OP_YY, OP_D6, OP_CX, OP_CY, OP_HU1, OP_HU2
  } op_t;

  typedef struct packed {
    logic                accept;
    logic                start;
    logic                capture;
    logic                norm_shift;
    logic                rot_load;
    logic                cordic_en;
    logic                publish;
    op_t                 op;
    logic [STEP_W-1:0]   step;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic norm_done;
    logic out_free;
  } sts_t;

  // Arctangent of 2^-i in units of 2^-24 rad.
  function automatic logic signed [ANG_W-1:0] step_angle(input logic [STEP_W-1:0] idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      5'd0:  a = ANG_W'(13176795);
      5'd1:  a = ANG_W'(7778716);
      5'd2:  a = ANG_W'(4110060);
      5'd3:  a = ANG_W'(2086331);
      5'd4:  a = ANG_W'(1047214);
      5'd5:  a = ANG_W'(524117);
      5'd6:  a = ANG_W'(262123);
      5'd7:  a = ANG_W'(131069);
      5'd8:  a = ANG_W'(65536);
      5'd9:  a = ANG_W'(32768);
      5'd10: a = ANG_W'(16384);
      5'd11: a = ANG_W'(8192);
      5'd12: a = ANG_W'(4096);
      5'd13: a = ANG_W'(2048);
      5'd14: a = ANG_W'(1024);
      5'd15: a = ANG_W'(512);
      5'd16: a = ANG_W'(256);
      5'd17: a = ANG_W'(128);
      5'd18: a = ANG_W'(64);
      5'd19: a = ANG_W'(32);
      5'd20: a = ANG_W'(16);
      5'd21: a = ANG_W'(8);
      5'd22: a = ANG_W'(4);
      5'd23: a = ANG_W'(2);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== design/rmsf_mul.sv =====
`default_nettype none
module rmsf_mul #(
  parameter int OP_W  = 67,
  parameter int PRD_W = 166
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [OP_W-1:0]   a,
  input  wire logic [OP_W-1:0]   b,
  output logic                   busy,
  output logic                   done,
  output logic [PRD_W-1:0]       p
);

  logic [PRD_W-1:0] a_r;
  logic [OP_W-1:0]  b_r;
  logic [PRD_W-1:0] p_r;
  logic             busy_r;
  logic             done_r;

  // Shift-add: one multiplier bit per cycle, stops once the rest is zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (b_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= PRD_W'(a);
      b_r <= b;
      p_r <= '0;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        p_r <= p_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = p_r;

endmodule
`default_nettype wire

// ===== design/rmsf_div.sv =====
`default_nettype none
module rmsf_div #(
  parameter int NUM_W = 166
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [NUM_W-1:0]           num,
  input  wire logic [NUM_W-1:0]           den,
  output logic                            busy,
  output logic                            done,
  output logic [rmsf_pkg::HU_W-1:0]       q
);
  import rmsf_pkg::*;

  localparam int CNT_W = $clog2(HU_W);

  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] dsh_r;
  logic [HU_W-1:0]  q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             chk_r;
  logic             busy_r;
  logic             done_r;
  logic             ge;

  assign ge = (num_r >= dsh_r);

  // The first cycle checks for overflow against den * 2^32, then one
  // quotient bit is resolved per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      chk_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        chk_r  <= 1'b1;
        cnt_r  <= CNT_W'(HU_W - 1);
      end else if (busy_r) begin
        if (chk_r) begin
          chk_r <= 1'b0;
          if (ge) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end else if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      dsh_r <= den << HU_W;
      q_r   <= '0;
    end else if (busy_r) begin
      dsh_r <= dsh_r >> 1;
      if (chk_r) begin
        if (ge) begin
          q_r <= '1;
        end
      end else begin
        if (ge) begin
          num_r <= num_r - dsh_r;
        end
        q_r <= {q_r[HU_W-2:0], ge};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign q    = q_r;

endmodule
`default_nettype wire

// ===== design/rmsf_dp.sv =====
`default_nettype none
module rmsf_dp #(
  parameter int COORD_BITS = rmsf_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rmsf_pkg::cmd_t                cmd,
  output rmsf_pkg::sts_t                     sts,
  input  wire logic                          in_tvalid,
  input  wire logic [rmsf_pkg::PIX_W-1:0]    pixel_x,
  input  wire logic [rmsf_pkg::PIX_W-1:0]    pixel_y,
  input  wire logic                          cfg_valid,
  input  wire logic [rmsf_pkg::AREA_W-1:0]   cfg_data,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [rmsf_pkg::AREA_W-1:0]        area,
  output logic [rmsf_pkg::PIX_W-1:0]         centroid_x,
  output logic [rmsf_pkg::PIX_W-1:0]         centroid_y,
  output logic [rmsf_pkg::HU_W-1:0]          hu_first,
  output logic [rmsf_pkg::HU_W-1:0]          hu_second,
  output logic signed [rmsf_pkg::ORI_W-1:0]  orientation,
  output logic                               region_valid
);
  import rmsf_pkg::*;

  localparam int XW = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam int SW = AREA_W - 1 + XW;
  localparam int QW = AREA_W - 1 + 2 * XW;
  localparam int MW = 2 * (AREA_W - 1) + 2 * XW + 1;
  localparam int WW = 2 * MW + HU_W;

  // Raw moment accumulators.
  logic [AREA_W-1:0] cnt_r;
  logic [SW-1:0]     sx_r, sy_r;
  logic [QW-1:0]     sxx_r, syy_r, sxy_r;
  logic [XW-1:0]     px, py;
  logic [2*XW-1:0]   pxx, pyy, pxy;
  logic              acc_en;

  assign px     = pixel_x[XW-1:0];
  assign py     = pixel_y[XW-1:0];
  assign pxx    = px * px;
  assign pyy    = py * py;
  assign pxy    = px * py;
  assign acc_en = cmd.accept && in_tvalid && (cnt_r < AREA_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.publish) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else if (acc_en) begin
      cnt_r <= cnt_r + 1'b1;
      sx_r  <= sx_r + SW'(px);
      sy_r  <= sy_r + SW'(py);
      sxx_r <= sxx_r + QW'(pxx);
      syy_r <= syy_r + QW'(pyy);
      sxy_r <= sxy_r + QW'(pxy);
    end
  end

  logic [AREA_W-1:0] min_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_SIZE_RST;
    end else if (cfg_valid) begin
      min_r <= cfg_data;
    end
  end

  // Central moments are held scaled by the area: U = N*m2 - m1*m1.
  logic [MW-1:0]        t_r, n3_r;
  logic signed [MW:0]   u20_r, u02_r, u11_r;
  logic [WW-1:0]        sq_r, d6_r;
  logic [PIX_W-1:0]     cx_r, cy_r;
  logic [HU_W-1:0]      hu1_r, hu2_r;

  logic [AREA_W-1:0]    nz;
  logic signed [MW+1:0] xd;
  logic signed [MW+1:0] xabs;
  logic signed [MW:0]   uabs;
  logic [MW-1:0]        xm, ym;
  logic                 xneg, yneg;
  logic [MW:0]          usum;

  assign nz   = (cnt_r == '0) ? AREA_W'(1) : cnt_r;
  assign xd   = $signed({u20_r[MW], u20_r}) - $signed({u02_r[MW], u02_r});
  assign xneg = xd[MW+1];
  assign xabs = xneg ? -xd : xd;
  assign xm   = xabs[MW-1:0];
  assign yneg = u11_r[MW];
  assign uabs = yneg ? -u11_r : u11_r;
  assign ym   = {uabs[MW-2:0], 1'b0};
  assign usum = (MW+1)'(u20_r[MW-1:0]) + (MW+1)'(u02_r[MW-1:0]);

  logic [MW-1:0]   mul_a, mul_b;
  logic [WW-1:0]   div_num, div_den;
  logic            use_div;
  logic            mul_busy, mul_done, div_busy, div_done;
  logic [WW-1:0]   mul_p;
  logic [HU_W-1:0] div_q;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    use_div = 1'b0;
    case (cmd.op)
      OP_NN: begin
        mul_a = MW'(nz);
        mul_b = MW'(nz);
      end
      OP_N3: begin
        mul_a = t_r;
        mul_b = MW'(nz);
      end
      OP_NXX: begin
        mul_a = MW'(nz);
        mul_b = MW'(sxx_r);
      end
      OP_SXX: begin
        mul_a = MW'(sx_r);
        mul_b = MW'(sx_r);
      end
      OP_NYY: begin
        mul_a = MW'(nz);
        mul_b = MW'(syy_r);
      end
      OP_SYY: begin
        mul_a = MW'(sy_r);
        mul_b = MW'(sy_r);
      end
      OP_NXY: begin
        mul_a = MW'(nz);
        mul_b = MW'(sxy_r);
      end
      OP_SXY: begin
        mul_a = MW'(sx_r);
        mul_b = MW'(sy_r);
      end
      OP_XX: begin
        mul_a = xm;
        mul_b = xm;
      end
      OP_YY: begin
        mul_a = ym;
        mul_b = ym;
      end
      OP_D6: begin
        mul_a = n3_r;
        mul_b = n3_r;
      end
      OP_CX: begin
        use_div = 1'b1;
        div_num = WW'(sx_r);
        div_den = WW'(nz);
      end
      OP_CY: begin
        use_div = 1'b1;
        div_num = WW'(sy_r);
        div_den = WW'(nz);
      end
      OP_HU1: begin
        use_div = 1'b1;
        div_num = WW'(usum) << HU_FRAC;
        div_den = WW'(n3_r);
      end
      OP_HU2: begin
        use_div = 1'b1;
        div_num = sq_r << HU_FRAC;
        div_den = d6_r;
      end
      default: begin
        use_div = 1'b0;
      end
    endcase
  end

  rmsf_mul #(
    .OP_W  (MW),
    .PRD_W (WW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && !use_div),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  rmsf_div #(
    .NUM_W (WW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && use_div),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .q     (div_q)
  );

  logic               unit_done;
  logic signed [MW:0] diff;

  assign unit_done = mul_done || div_done;
  assign diff      = $signed({1'b0, t_r}) - $signed({1'b0, mul_p[MW-1:0]});

  always_ff @(posedge clk) begin
    if (unit_done) begin
      case (cmd.op)
        OP_NN:  t_r   <= mul_p[MW-1:0];
        OP_N3:  n3_r  <= mul_p[MW-1:0];
        OP_NXX: t_r   <= mul_p[MW-1:0];
        OP_SXX: u20_r <= diff;
        OP_NYY: t_r   <= mul_p[MW-1:0];
        OP_SYY: u02_r <= diff;
        OP_NXY: t_r   <= mul_p[MW-1:0];
        OP_SXY: u11_r <= diff;
        OP_XX:  sq_r  <= mul_p;
        OP_YY:  sq_r  <= sq_r + mul_p;
        OP_D6:  d6_r  <= mul_p;
        OP_CX:  cx_r  <= div_q[PIX_W-1:0];
        OP_CY:  cy_r  <= div_q[PIX_W-1:0];
        OP_HU1: hu1_r <= div_q;
        OP_HU2: hu2_r <= div_q;
        default: t_r  <= t_r;
      endcase
    end
  end

  // Orientation: scale both components below 2^30, then CORDIC vectoring.
  logic [MW-1:0]              xn_r, yn_r;
  logic                       xneg_r, yneg_r;
  logic signed [CORD_W-1:0]   x_r, y_r;
  logic signed [ANG_W-1:0]    ang_r;
  logic                       norm_done;
  logic signed [CORD_W-1:0]   xv, yv, x0, y0, xs, ys;
  logic                       y_pos, y_neg;
  logic signed [ANG_W-1:0]    sa;

  assign norm_done = ~|(xn_r[MW-1:NORM_W] | yn_r[MW-1:NORM_W]);
  assign xv    = $signed({{(CORD_W-NORM_W){1'b0}}, xn_r[NORM_W-1:0]});
  assign yv    = $signed({{(CORD_W-NORM_W){1'b0}}, yn_r[NORM_W-1:0]});
  assign x0    = xneg_r ? -xv : xv;
  assign y0    = yneg_r ? -yv : yv;
  assign xs    = x_r >>> cmd.step;
  assign ys    = y_r >>> cmd.step;
  assign y_neg = y_r[CORD_W-1];
  assign y_pos = !y_neg && (y_r != '0);
  assign sa    = step_angle(cmd.step);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xn_r   <= xm;
      yn_r   <= ym;
      xneg_r <= xneg;
      yneg_r <= yneg;
    end else if (cmd.norm_shift) begin
      xn_r <= xn_r >> 1;
      yn_r <= yn_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rot_load) begin
      if (x0[CORD_W-1]) begin
        if (!y0[CORD_W-1]) begin
          x_r   <= y0;
          y_r   <= -x0;
          ang_r <= ANG_HALF_PI;
        end else begin
          x_r   <= -y0;
          y_r   <= x0;
          ang_r <= -ANG_HALF_PI;
        end
      end else begin
        x_r   <= x0;
        y_r   <= y0;
        ang_r <= '0;
      end
    end else if (cmd.cordic_en) begin
      if (y_pos) begin
        x_r   <= x_r + ys;
        y_r   <= y_r - xs;
        ang_r <= ang_r + sa;
      end else if (y_neg) begin
        x_r   <= x_r - ys;
        y_r   <= y_r + xs;
        ang_r <= ang_r - sa;
      end
    end
  end

  logic signed [ANG_W-1:0] rsh, rcl;
  assign rsh = (ang_r + ROUND_HALF) >>> 12;

  always_comb begin
    if (rsh > ORI_MAX) begin
      rcl = ORI_MAX;
    end else if (rsh < -ORI_MAX) begin
      rcl = -ORI_MAX;
    end else begin
      rcl = rsh;
    end
  end

  // Result register parts the computation from the output handshake.
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      area         <= cnt_r;
      centroid_x   <= cx_r;
      centroid_y   <= cy_r;
      hu_first     <= hu1_r;
      hu_second    <= hu2_r;
      orientation  <= rcl[ORI_W-1:0];
      region_valid <= (cnt_r >= min_r);
    end
  end

  assign out_tvalid    = out_valid_r;
  assign sts.unit_done = unit_done;
  assign sts.norm_done = norm_done;
  assign sts.out_free  = !out_valid_r || out_tready;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !mul_busy && !div_busy)
    else $error("arithmetic unit started while busy");

  a_clear_after_publish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> (cnt_r == '0) && (sx_r == '0) && (sxx_r == '0))
    else $error("accumulators not cleared after a result");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_tvalid && (cnt_r == AREA_MAX)) |=> $stable(cnt_r) && $stable(sx_r))
    else $error("pixel counted beyond the area limit");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rot_load |-> norm_done)
    else $error("CORDIC loaded before normalization finished");

endmodule
`default_nettype wire

// ===== design/rmsf_ctrl.sv =====
`default_nettype none
module rmsf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tlast,
  input  wire rmsf_pkg::sts_t   sts,
  output rmsf_pkg::cmd_t        cmd
);
  import rmsf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LAUNCH, S_WAIT, S_CAPT, S_NORM, S_ROT, S_CORD, S_HOLD
  } state_t;

  state_t            state_r;
  op_t               op_r;
  logic [STEP_W-1:0] step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_NN;
      step_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tlast) begin
            op_r    <= OP_NN;
            state_r <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (sts.unit_done) begin
            if (op_r == OP_HU2) begin
              state_r <= S_CAPT;
            end else begin
              op_r    <= op_t'(4'(op_r) + 4'd1);
              state_r <= S_LAUNCH;
            end
          end
        end
        S_CAPT: begin
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (sts.norm_done) begin
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          step_r  <= '0;
          state_r <= S_CORD;
        end
        S_CORD: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.op         = op_r;
    cmd.step       = step_r;
    cmd.accept     = (state_r == S_IDLE);
    cmd.start      = (state_r == S_LAUNCH);
    cmd.capture    = (state_r == S_CAPT);
    cmd.norm_shift = (state_r == S_NORM) && !sts.norm_done;
    cmd.rot_load   = (state_r == S_ROT);
    cmd.cordic_en  = (state_r == S_CORD);
    cmd.publish    = (state_r == S_HOLD) && sts.out_free;
  end

endmodule
`default_nettype wire

// ===== design/region_moment_shape_features.sv =====
// Pixels are accepted one per cycle while a region accumulates.
// After the last pixel the input stalls for the result computation, done by the
// shift-add multiplier (one multiplier bit per cycle, eleven products) and the
// restoring divider (four quotients), and longer while the previous result waits
// to be taken.
// Reset (synchronous, rst_n low) clears the accumulators and the pending
// result and sets the minimum region size to 20000; no clearing pass.
`default_nettype none
module region_moment_shape_features #(
  parameter int COORD_BITS = rmsf_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // pixel_x[10:0], pixel_y[21:11], zero fill
  input  wire logic [rmsf_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // area[22:0], centroid_x[33:23], centroid_y[44:34], hu_first[76:45],
  // hu_second[108:77], orientation[123:109], zero fill
  output logic [rmsf_pkg::OUT_DATA_W-1:0]          out_tdata,
  // region_valid[0]
  output logic [0:0]                               out_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rmsf_pkg::AREA_W-1:0]         cfg_data
);
  import rmsf_pkg::*;

  cmd_t                     cmd;
  sts_t                     sts;
  logic [AREA_W-1:0]        area;
  logic [PIX_W-1:0]         centroid_x, centroid_y;
  logic [HU_W-1:0]          hu_first, hu_second;
  logic signed [ORI_W-1:0]  orientation;
  logic                     region_valid;

  rmsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmsf_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_tvalid    (in_tvalid),
    .pixel_x      (in_tdata[PIX_W-1:0]),
    .pixel_y      (in_tdata[2*PIX_W-1:PIX_W]),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .area         (area),
    .centroid_x   (centroid_x),
    .centroid_y   (centroid_y),
    .hu_first     (hu_first),
    .hu_second    (hu_second),
    .orientation  (orientation),
    .region_valid (region_valid)
  );

  assign in_tready = cmd.accept;
  assign cfg_ready = 1'b1;
  assign out_tdata = OUT_DATA_W'({orientation, hu_second, hu_first,
                                  centroid_y, centroid_x, area});
  assign out_tuser = region_valid;

endmodule
`default_nettype wire
